@@ sv/bap_pkg.sv @@
// ----------------------------------------------------------------------------
// bap_pkg
// Types and constants for the breadth-first augmenting path block.
// ----------------------------------------------------------------------------
package bap_pkg;

  localparam int NODE_W = 6;
  localparam int LEN_W  = 7;
  localparam int CAP_W  = 31;
  localparam int FLOW_W = 32;
  localparam int AMT_W  = 30;
  localparam int CFG_W  = 6;

  localparam logic [AMT_W-1:0] START_AMOUNT = 30'h3f3f3f3f;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_SINK   = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [NODE_W-1:0]        tail_node;
    logic [NODE_W-1:0]        head_node;
    logic [CAP_W-1:0]         capacity;
    logic signed [FLOW_W-1:0] initial_flow;
  } in_item_t;

  typedef struct packed {
    logic              path_found;
    logic [LEN_W-1:0]  path_length;
    logic [AMT_W-1:0]  bottleneck;
    logic [NODE_W-1:0] path_node;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] tail;
    logic [NODE_W-1:0] head;
    logic [CAP_W-1:0]  cap;
  } edge_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_REV,
    ST_INIT,
    ST_DEQ,
    ST_DEQ_X,
    ST_DEQ_A,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_DONE_CHK,
    ST_AUG_B,
    ST_AUG_CHK,
    ST_AUG_E,
    ST_AUG_F1,
    ST_AUG_F2,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_NF_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic add_fwd;
    logic add_rev;
    logic init;
    logic deq_rd;
    logic deq_x;
    logic deq_a;
    logic scan_rd;
    logic scan_ev;
    logic sink_rd;
    logic aug_b;
    logic aug_step;
    logic aug_src;
    logic aug_e;
    logic aug_f1;
    logic aug_f2;
    logic emit_rd;
    logic emit_ld;
    logic nf_ld;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic add_ok;
    logic run_bad;
    logic q_empty;
    logic scan_end;
    logic sink_hit;
    logic aug_end;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

@@ sv/bap_ram.sv @@
// ----------------------------------------------------------------------------
// bap_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bap_ctrl.sv @@
// ----------------------------------------------------------------------------
// bap_ctrl
// Sequencer for edge loading, search, augmentation and path output.
// ----------------------------------------------------------------------------
module bap_ctrl
  import bap_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.op == OP_ADD_EDGE) begin
            if (sts.add_ok) begin
              cmd.add_fwd = 1'b1;
              state_nxt   = ST_ADD_REV;
            end
          end else if (sts.run_bad) begin
            state_nxt = ST_NF_OUT;
          end else begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_ADD_REV: begin
        cmd.add_rev = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_DEQ;
      end
      ST_DEQ: begin
        if (sts.q_empty) begin
          state_nxt = ST_DONE_CHK;
        end else begin
          cmd.deq_rd = 1'b1;
          state_nxt  = ST_DEQ_X;
        end
      end
      ST_DEQ_X: begin
        cmd.deq_x = 1'b1;
        state_nxt = ST_DEQ_A;
      end
      ST_DEQ_A: begin
        cmd.deq_a = 1'b1;
        state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (sts.scan_end) begin
          state_nxt = sts.sink_hit ? ST_DONE_CHK : ST_DEQ;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_nxt   = ST_SCAN_RD;
      end
      ST_DONE_CHK: begin
        if (sts.sink_hit) begin
          cmd.sink_rd = 1'b1;
          state_nxt   = ST_AUG_B;
        end else begin
          state_nxt = ST_NF_OUT;
        end
      end
      ST_AUG_B: begin
        cmd.aug_b = 1'b1;
        state_nxt = ST_AUG_CHK;
      end
      ST_AUG_CHK: begin
        if (sts.aug_end) begin
          cmd.aug_src = 1'b1;
          state_nxt   = ST_EMIT_RD;
        end else begin
          cmd.aug_step = 1'b1;
          state_nxt    = ST_AUG_E;
        end
      end
      ST_AUG_E: begin
        cmd.aug_e = 1'b1;
        state_nxt = ST_AUG_F1;
      end
      ST_AUG_F1: begin
        cmd.aug_f1 = 1'b1;
        state_nxt  = ST_AUG_F2;
      end
      ST_AUG_F2: begin
        cmd.aug_f2 = 1'b1;
        state_nxt  = ST_AUG_CHK;
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_NF_OUT: begin
        if (sts.out_free) begin
          cmd.nf_ld = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/bap_dp.sv @@
// ----------------------------------------------------------------------------
// bap_dp
// Edge tables, search queue, node tables, flow update and output word.
// ----------------------------------------------------------------------------
module bap_dp
  import bap_pkg::*;
#(
  parameter int NODES = 64,
  parameter int EDGES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  in_item_t           in_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               out_stall,
  output logic               out_valid,
  output out_item_t          out_data,
  input  cmd_t               cmd,
  output status_t            sts
);

  localparam int SLOTS = 2 * EDGES;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int NW    = $clog2(NODES);
  localparam int QW    = $clog2(NODES + 1);

  logic [NODE_W-1:0] src_r, src_nxt, snk_r, snk_nxt;
  in_item_t          item_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic [QW-1:0]     qhead_r, qhead_nxt, qtail_r, qtail_nxt;
  logic [NODES-1:0]  vld_r, vld_nxt;
  logic [NW-1:0]     x_r, x_nxt, u_r, u_nxt;
  logic [AMT_W-1:0]  amt_r, amt_nxt, b_r, b_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt, j_r, j_nxt;
  logic [SW-1:0]     e_r, e_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [NW-1:0]     s_idx, t_idx, to_idx;
  logic [SW-1:0]     e_pair;
  logic [CW:0]       cnt_plus2;

  // memory ports
  logic              ed_we, ed_re;
  logic [SW-1:0]     ed_wa, ed_ra;
  edge_t             ed_wd, ed_rd;
  logic              fl_we, fl_re;
  logic [SW-1:0]     fl_wa, fl_ra;
  logic [FLOW_W-1:0] fl_wd, fl_rd;
  logic              ra_we, ra_re;
  logic [NW-1:0]     ra_wa, ra_ra;
  logic [AMT_W-1:0]  ra_wd, ra_rd;
  logic              pr_we;
  logic [SW-1:0]     pr_rd;
  logic              q_we;
  logic [NW-1:0]     q_wa, q_wd, q_rd;
  logic              pa_we;
  logic [NW-1:0]     pa_wa, pa_wd, pa_rd;

  logic signed [FLOW_W:0] spare;
  logic                   spare_pos, amt_lt, take;
  logic [AMT_W-1:0]       new_amt;

  assign s_idx     = src_r[NW-1:0];
  assign t_idx     = snk_r[NW-1:0];
  assign to_idx    = ed_rd.head[NW-1:0];
  assign e_pair    = e_r ^ SW'(1);
  assign cnt_plus2 = {1'b0, cnt_r} + (CW+1)'(2);

  assign spare     = $signed({2'b00, ed_rd.cap}) - $signed({fl_rd[FLOW_W-1], fl_rd});
  assign spare_pos = !spare[FLOW_W] && (spare != '0);
  assign amt_lt    = {3'b000, amt_r} < spare;
  assign new_amt   = amt_lt ? amt_r : spare[AMT_W-1:0];
  assign take      = cmd.scan_ev && (ed_rd.tail == NODE_W'(x_r))
                     && ({1'b0, ed_rd.head} < (NODE_W+1)'(NODES))
                     && !vld_r[to_idx] && spare_pos;

  always_comb begin
    sts.op        = in_data.operation;
    sts.add_ok    = ({1'b0, in_data.tail_node} < (NODE_W+1)'(NODES))
                    && ({1'b0, in_data.head_node} < (NODE_W+1)'(NODES))
                    && (cnt_plus2 <= (CW+1)'(SLOTS));
    sts.run_bad   = ({1'b0, src_r} >= (NODE_W+1)'(NODES))
                    || ({1'b0, snk_r} >= (NODE_W+1)'(NODES));
    sts.q_empty   = qhead_r == qtail_r;
    sts.scan_end  = scan_r == cnt_r;
    sts.sink_hit  = vld_r[t_idx];
    sts.aug_end   = (u_r == s_idx) || (len_r == LEN_W'(NODES - 1));
    sts.emit_last = j_r == '0;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // memory port steering
  always_comb begin
    ed_we = cmd.add_fwd || cmd.add_rev;
    ed_wa = cmd.add_fwd ? cnt_r[SW-1:0] : (cnt_r[SW-1:0] + SW'(1));
    ed_wd = cmd.add_fwd ? edge_t'{in_data.tail_node, in_data.head_node, in_data.capacity}
                        : edge_t'{item_r.head_node, item_r.tail_node, '0};
    ed_re = cmd.scan_rd || cmd.aug_e;
    ed_ra = cmd.scan_rd ? scan_r[SW-1:0] : pr_rd;

    fl_we = cmd.add_fwd || cmd.add_rev || cmd.aug_f1 || cmd.aug_f2;
    fl_wa = ed_wa;
    fl_wd = '0;
    priority if (cmd.add_fwd) begin
      fl_wd = in_data.initial_flow;
    end else if (cmd.aug_f1) begin
      fl_wa = e_r;
      fl_wd = fl_rd + {2'b00, b_r};
    end else if (cmd.aug_f2) begin
      fl_wa = e_pair;
      fl_wd = fl_rd - {2'b00, b_r};
    end else begin
      fl_wd = '0;
    end
    fl_re = cmd.scan_rd || cmd.aug_e || cmd.aug_f1;
    fl_ra = cmd.scan_rd ? scan_r[SW-1:0] : (cmd.aug_e ? pr_rd : e_pair);

    ra_we = cmd.init || take;
    ra_wa = cmd.init ? s_idx : to_idx;
    ra_wd = cmd.init ? START_AMOUNT : new_amt;
    ra_re = cmd.deq_x || cmd.sink_rd;
    ra_ra = cmd.deq_x ? q_rd : t_idx;

    pr_we = take;

    q_we  = cmd.init || (take && (qtail_r < QW'(NODES)));
    q_wa  = cmd.init ? '0 : qtail_r[NW-1:0];
    q_wd  = cmd.init ? s_idx : to_idx;

    pa_we = cmd.aug_step || cmd.aug_src;
    pa_wa = len_r[NW-1:0];
    pa_wd = cmd.aug_src ? s_idx : u_r;
  end

  bap_ram #(.WIDTH($bits(edge_t)), .DEPTH(SLOTS)) u_edge_ram (
    .clk, .we(ed_we), .waddr(ed_wa), .wdata(ed_wd), .re(ed_re), .raddr(ed_ra), .rdata(ed_rd)
  );
  bap_ram #(.WIDTH(FLOW_W), .DEPTH(SLOTS)) u_flow_ram (
    .clk, .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .re(fl_re), .raddr(fl_ra), .rdata(fl_rd)
  );
  bap_ram #(.WIDTH(AMT_W), .DEPTH(NODES)) u_amt_ram (
    .clk, .we(ra_we), .waddr(ra_wa), .wdata(ra_wd), .re(ra_re), .raddr(ra_ra), .rdata(ra_rd)
  );
  bap_ram #(.WIDTH(SW), .DEPTH(NODES)) u_pred_ram (
    .clk, .we(pr_we), .waddr(to_idx), .wdata(scan_r[SW-1:0]), .re(cmd.aug_step),
    .raddr(u_r), .rdata(pr_rd)
  );
  bap_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue_ram (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .re(cmd.deq_rd),
    .raddr(qhead_r[NW-1:0]), .rdata(q_rd)
  );
  bap_ram #(.WIDTH(NW), .DEPTH(NODES)) u_path_ram (
    .clk, .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .re(cmd.emit_rd),
    .raddr(j_r[NW-1:0]), .rdata(pa_rd)
  );

  always_comb begin
    src_nxt       = src_r;
    snk_nxt       = snk_r;
    cnt_nxt       = cnt_r;
    scan_nxt      = scan_r;
    qhead_nxt     = qhead_r;
    qtail_nxt     = qtail_r;
    vld_nxt       = vld_r;
    x_nxt         = x_r;
    u_nxt         = u_r;
    amt_nxt       = amt_r;
    b_nxt         = b_r;
    len_nxt       = len_r;
    j_nxt         = j_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCE: src_nxt = cfg_data;
        CFG_SINK:   snk_nxt = cfg_data;
        default:    src_nxt = src_r;
      endcase
    end
    if (cmd.add_rev) begin
      cnt_nxt = cnt_plus2[CW-1:0];
    end
    if (cmd.init) begin
      vld_nxt        = '0;
      vld_nxt[s_idx] = 1'b1;
      qhead_nxt      = '0;
      qtail_nxt      = QW'(1);
    end
    if (cmd.deq_rd) begin
      qhead_nxt = qhead_r + QW'(1);
    end
    if (cmd.deq_x) begin
      x_nxt = q_rd;
    end
    if (cmd.deq_a) begin
      amt_nxt  = ra_rd;
      scan_nxt = '0;
    end
    if (cmd.scan_ev) begin
      scan_nxt = scan_r + CW'(1);
    end
    if (take) begin
      vld_nxt[to_idx] = 1'b1;
      if (qtail_r < QW'(NODES)) begin
        qtail_nxt = qtail_r + QW'(1);
      end
    end
    if (cmd.aug_b) begin
      b_nxt   = ra_rd;
      u_nxt   = t_idx;
      len_nxt = '0;
    end
    if (cmd.aug_step) begin
      len_nxt = len_r + LEN_W'(1);
    end
    if (cmd.aug_src) begin
      len_nxt = len_r + LEN_W'(1);
      j_nxt   = len_r;
    end
    if (cmd.aug_e) begin
      e_nxt = pr_rd;
    end
    if (cmd.aug_f1) begin
      u_nxt = ed_rd.tail[NW-1:0];
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_ld) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.path_found  = 1'b1;
      out_data_nxt.path_length = len_r;
      out_data_nxt.bottleneck  = b_r;
      out_data_nxt.path_node   = NODE_W'(pa_rd);
      out_data_nxt.last        = j_r == '0;
      j_nxt                    = j_r - LEN_W'(1);
    end
    if (cmd.nf_ld) begin
      out_valid_nxt     = 1'b1;
      out_data_nxt      = '0;
      out_data_nxt.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r       <= '0;
      snk_r       <= NODE_W'(1);
      cnt_r       <= '0;
      vld_r       <= '0;
      qhead_r     <= '0;
      qtail_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      src_r       <= src_nxt;
      snk_r       <= snk_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      qhead_r     <= qhead_nxt;
      qtail_r     <= qtail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    scan_r     <= scan_nxt;
    x_r        <= x_nxt;
    u_r        <= u_nxt;
    amt_r      <= amt_nxt;
    b_r        <= b_nxt;
    len_r      <= len_nxt;
    j_r        <= j_nxt;
    e_r        <= e_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/bfs_augmenting_path.sv @@
// Add edge: a stored edge writes its forward slot, then its reverse slot; an ignored one is dropped.
// Run: a breadth-first search that reads one edge slot at a time, bounded by the
// single edge-table read port, then a flow update per path edge and a word per emitted node.
// A run that finds nothing gives its single word once the search ends.
// rst_n is synchronous, active low: clears slot count, source 0, sink 1, output empty.
// Edge tables hold no reset value; only slots below the count are ever read.
// ----------------------------------------------------------------------------
// bfs_augmenting_path
// Breadth-first augmenting-path step of a max-flow network, top level.
// ----------------------------------------------------------------------------
module bfs_augmenting_path
  import bap_pkg::*;
#(
  parameter int NODES = 64,
  parameter int EDGES = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  bap_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .sts, .cmd
  );

  bap_dp #(.NODES(NODES), .EDGES(EDGES)) u_dp (
    .clk, .rst_n, .in_data, .cfg_we, .cfg_index, .cfg_data,
    .out_stall, .out_valid, .out_data, .cmd, .sts
  );

endmodule

@@ sv/bap_checker.sv @@
// ----------------------------------------------------------------------------
// bap_checker
// Port-level checks for the augmenting path block.
// ----------------------------------------------------------------------------
module bap_checker
  import bap_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == OP_RUN) |=> in_stall)
    else $error("run word accepted without going busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.path_found |-> out_data.last && (out_data.path_length == '0))
    else $error("not-found word malformed");

  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.path_found |-> (out_data.path_length != '0)
      && (out_data.bottleneck != '0))
    else $error("found word with empty path or zero bottleneck");

endmodule

bind bfs_augmenting_path bap_checker u_bap_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);

@@ tb/bfs_augmenting_path_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfs_augmenting_path_test
// Loads directed and random flow networks into the augmenting-path block, runs
// path searches under several source/sink settings and random handshake gaps,
// and compares every emitted path word with a behavioral max-flow step model.
// ----------------------------------------------------------------------------
module bfs_augmenting_path_test;
  import bap_pkg::*;

  localparam int NODES = 64;
  localparam int EDGES = 48;
  localparam int SLOTS = 2 * EDGES;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_SOURCE;
  logic [CFG_W-1:0] cfg_data = '0;

  bfs_augmenting_path #(.NODES(NODES), .EDGES(EDGES)) uut (.*);

  always #5 clk = ~clk;

  logic [NODE_W-1:0] net_tail [SLOTS];
  logic [NODE_W-1:0] net_head [SLOTS];
  logic [CAP_W-1:0]  net_cap  [SLOTS];
  logic [FLOW_W-1:0] net_flow [SLOTS];
  int                slot_count;
  logic [NODE_W-1:0] src_node, dst_node;
  out_item_t         path_words [$];
  int                mismatches = 0;
  int                burst_left;
  int                stall_mode;

  function automatic out_item_t nf_word();
    out_item_t w;
    w = '0;
    w.last = 1'b1;
    return w;
  endfunction

  task automatic predict_step(input in_item_t it);
    logic [AMT_W-1:0] amount [NODES];
    int               pred [NODES];
    int               queue [$];
    int               path [$];
    int               x, to, e, u, len;
    longint           spare;
    logic [AMT_W-1:0] b;
    out_item_t        w;
    if (it.operation == OP_ADD_EDGE) begin
      if (slot_count + 2 > SLOTS) return;
      net_tail[slot_count] = it.tail_node;
      net_head[slot_count] = it.head_node;
      net_cap[slot_count] = it.capacity;
      net_flow[slot_count] = it.initial_flow;
      net_tail[slot_count+1] = it.head_node;
      net_head[slot_count+1] = it.tail_node;
      net_cap[slot_count+1] = '0;
      net_flow[slot_count+1] = '0;
      slot_count += 2;
      return;
    end
    foreach (amount[i]) amount[i] = '0;
    amount[src_node] = START_AMOUNT;
    queue = {queue, int'(src_node)};
    while (queue.size() > 0) begin
      x = queue.pop_front();
      for (int i = 0; i < slot_count; i++) begin
        if (net_tail[i] != x) continue;
        to = net_head[i];
        if (amount[to] != 0) continue;
        spare = longint'(net_cap[i]) - longint'($signed(net_flow[i]));
        if (spare <= 0) continue;
        pred[to] = i;
        amount[to] = (longint'(amount[x]) < spare) ? amount[x] : AMT_W'(spare);
        queue = {queue, to};
      end
      if (amount[dst_node] != 0) break;
    end
    if (amount[dst_node] == 0) begin
      path_words = {path_words, nf_word()};
      return;
    end
    b = amount[dst_node];
    u = dst_node;
    while (u != src_node && path.size() < NODES - 1) begin
      e = pred[u];
      path.push_front(u);
      net_flow[e] += FLOW_W'(b);
      net_flow[e ^ 1] -= FLOW_W'(b);
      u = net_tail[e];
    end
    path.push_front(src_node);
    len = path.size();
    foreach (path[k]) begin
      w.path_found = 1'b1;
      w.path_length = LEN_W'(len);
      w.bottleneck = b;
      w.path_node = NODE_W'(path[k]);
      w.last = (k == len - 1);
      path_words = {path_words, w};
    end
  endtask

  // burst/gap pacing on the sending side
  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    predict_step(it);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic add_edge(input int t, input int h, input logic [CAP_W-1:0] c,
                          input logic [FLOW_W-1:0] f);
    in_item_t it;
    it = '0;
    it.operation = OP_ADD_EDGE;
    it.tail_node = NODE_W'(t);
    it.head_node = NODE_W'(h);
    it.capacity = c;
    it.initial_flow = f;
    send_item(it);
  endtask

  task automatic run_search();
    in_item_t it;
    it = '0;
    it.operation = OP_RUN;
    it.tail_node = NODE_W'($urandom);
    it.head_node = NODE_W'($urandom);
    it.capacity = CAP_W'($urandom);
    it.initial_flow = $urandom;
    send_item(it);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (path_words.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(v);
    if (idx == CFG_SOURCE) src_node = CFG_W'(v); else dst_node = CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    run_search();
    add_edge(0, 1, 31'h7fffffff, 32'h80000000);
    run_search();
    run_search();
    add_edge(0, 2, 10, 0);
    add_edge(2, 1, 31'h7fffffff, 32'h7fffffff);
    add_edge(2, 63, 5, 32'hffffffff);
    add_edge(63, 1, 0, 0);
    add_edge(63, 1, 100, 3);
    run_search();
    run_search();
    wait_idle();
    write_reg(CFG_SOURCE, 63);
    write_reg(CFG_SINK, 63);
    run_search();
    wait_idle();
    write_reg(CFG_SOURCE, 2);
    write_reg(CFG_SINK, 0);
    run_search();
    run_search();
    wait_idle();
  endtask

  task automatic test_random_networks();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_SOURCE, phase == 3 ? 0 : $urandom_range(0, 7));
      write_reg(CFG_SINK, phase == 3 ? 63 : $urandom_range(0, 7));
      for (int n = 0; n < 12; n++) begin
        if ($urandom_range(0, 3) == 0) run_search();
        else if ($urandom_range(0, 4) == 0)
          add_edge($urandom_range(0, 63), $urandom_range(0, 63), CAP_W'($urandom),
                   $urandom);
        else
          add_edge($urandom_range(0, 7), phase == 3 ? $urandom_range(0, 63)
                   : $urandom_range(0, 7), $urandom_range(0, 200),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50));
      end
      wait_idle();
    end
    // fill the table past its end
    for (int n = 0; n < 30; n++) add_edge(n % 64, (n + 1) % 64, 1000, 0);
    run_search();
    wait_idle();
  endtask

  always @(posedge clk) begin
    stall_mode <= ($urandom_range(0, 63) == 0) ? $urandom_range(0, 2) : stall_mode;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (path_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        want = path_words.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %h actual %h", want, out_data);
        end
      end
    end
  end

  initial begin
    slot_count = 0;
    burst_left = 0;
    src_node = '0;
    dst_node = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_networks();
    if (mismatches == 0 && path_words.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
